@@ rtl/life_automaton_torus_step_defines.svh @@
// Assertion macros used by the checker file.
`ifndef LIFE_AUTOMATON_TORUS_STEP_DEFINES_SVH
`define LIFE_AUTOMATON_TORUS_STEP_DEFINES_SVH

// Same-cycle implication, held off while reset is low.
`define LATS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is low.
`define LATS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lats_pkg.sv @@
package lats_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int CFG_W       = 7;
  localparam int CFG_ADDR_W  = 1;
  localparam int ACT_W       = 2;
  localparam int ROW_FIELD_W = 6;
  localparam int COL_FIELD_W = 6;
  localparam int NBR_W       = 4;

  localparam int MIN_SIZE = 3;
  localparam logic [CFG_W-1:0] GRID_SIZE_RESET = CFG_W'(64);

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLS = CFG_ADDR_W'(1);

  localparam logic [ACT_W-1:0] ACT_WRITE   = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_READ    = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_ADVANCE = ACT_W'(2);
  localparam logic [ACT_W-1:0] ACT_NONE    = ACT_W'(3);

  // B3/S23 neighbour counts
  localparam logic [NBR_W-1:0] NBR_BIRTH = NBR_W'(3);
  localparam logic [NBR_W-1:0] NBR_KEEP  = NBR_W'(2);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_FIN,
    ST_GEN_PRE0,
    ST_GEN_PRE1,
    ST_GEN_PRE2,
    ST_GEN_RD,
    ST_GEN_WR,
    ST_GEN_DONE,
    ST_DROP
  } lats_state_t;

  typedef struct packed {
    logic clr;
    logic take;
    logic cell_rd;
    logic cell_fin;
    logic gen_pre0;
    logic gen_pre1;
    logic gen_pre2;
    logic gen_rd;
    logic gen_wr;
    logic gen_swap;
  } lats_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic row_last;
    logic out_free;
  } lats_sts_t;

endpackage

@@ rtl/lats_if.sv @@
interface lats_in_if import lats_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [ACT_W-1:0]       action;
  logic [ROW_FIELD_W-1:0] row;
  logic [COL_FIELD_W-1:0] col;
  logic                   alive;

  modport source (output valid, output action, output row, output col, output alive,
                  input ready);
  modport sink   (input valid, input action, input row, input col, input alive,
                  output ready);
endinterface

interface lats_out_if import lats_pkg::*;;
  logic             valid;
  logic             ready;
  logic             cell_alive;
  logic [ACT_W-1:0] done_action;

  modport source (output valid, output cell_alive, output done_action, input ready);
  modport sink   (input valid, input cell_alive, input done_action, output ready);
endinterface

@@ rtl/lats_ram.sv @@
module lats_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/lats_ctrl.sv @@
module lats_ctrl import lats_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] in_action,
  output logic             in_ready,
  input  lats_sts_t        sts,
  output lats_cmd_t        cmd
);

  lats_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action inside {ACT_WRITE, ACT_READ}) begin
            state_nxt = ST_CELL_RD;
          end else if (in_action == ACT_ADVANCE) begin
            state_nxt = ST_GEN_PRE0;
          end else begin
            state_nxt = ST_DROP;
          end
        end
      end
      ST_CELL_RD:  state_nxt = ST_CELL_FIN;
      ST_CELL_FIN: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_GEN_PRE0: state_nxt = ST_GEN_PRE1;
      ST_GEN_PRE1: state_nxt = ST_GEN_PRE2;
      ST_GEN_PRE2: state_nxt = ST_GEN_RD;
      ST_GEN_RD:   state_nxt = ST_GEN_WR;
      ST_GEN_WR: begin
        state_nxt = sts.row_last ? ST_GEN_DONE : ST_GEN_RD;
      end
      ST_GEN_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_DROP:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    cmd          = '0;
    cmd.clr      = (state_r == ST_CLEAR);
    cmd.take     = in_valid && (state_r == ST_IDLE);
    cmd.cell_rd  = (state_r == ST_CELL_RD);
    cmd.cell_fin = (state_r == ST_CELL_FIN) && sts.out_free;
    cmd.gen_pre0 = (state_r == ST_GEN_PRE0);
    cmd.gen_pre1 = (state_r == ST_GEN_PRE1);
    cmd.gen_pre2 = (state_r == ST_GEN_PRE2);
    cmd.gen_rd   = (state_r == ST_GEN_RD);
    cmd.gen_wr   = (state_r == ST_GEN_WR);
    cmd.gen_swap = (state_r == ST_GEN_DONE) && sts.out_free;
  end

endmodule

@@ rtl/lats_dp.sv @@
module lats_dp import lats_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic [ACT_W-1:0]       in_action,
  input  logic [ROW_FIELD_W-1:0] in_row,
  input  logic [COL_FIELD_W-1:0] in_col,
  input  logic                   in_alive,
  input  lats_cmd_t              cmd,
  output lats_sts_t              sts,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_cell_alive,
  output logic [ACT_W-1:0]       out_done_action
);

  localparam int RA_W = $clog2(MAX_ROWS);
  localparam int CA_W = $clog2(MAX_COLS);
  localparam int RC_W = $clog2(MAX_ROWS + 1);
  localparam int CC_W = $clog2(MAX_COLS + 1);

  // cell pulled in from the left (bit c sees column c-1), column 0 wraps
  function automatic logic [MAX_COLS-1:0] from_left(input logic [MAX_COLS-1:0] v,
                                                    input logic [CA_W-1:0] lc);
    logic [MAX_COLS-1:0] res;
    res    = {v[MAX_COLS-2:0], v[MAX_COLS-1]};
    res[0] = v[lc];
    return res;
  endfunction

  // cell pulled in from the right (bit c sees column c+1), last column wraps
  function automatic logic [MAX_COLS-1:0] from_right(input logic [MAX_COLS-1:0] v,
                                                     input logic [CA_W-1:0] lc);
    logic [MAX_COLS-1:0] res;
    res     = {v[0], v[MAX_COLS-1:1]};
    res[lc] = v[0];
    return res;
  endfunction

  logic [CFG_W-1:0]    grid_rows_r, grid_cols_r;
  logic [RC_W-1:0]     rows_eff;
  logic [CC_W-1:0]     cols_eff;
  logic [RA_W-1:0]     last_row;
  logic [CA_W-1:0]     last_col;

  logic [ACT_W-1:0]    item_act_r;
  logic                item_alive_r;
  logic [RA_W-1:0]     item_row_r;
  logic [CA_W-1:0]     item_col_r;

  logic                sel_r;
  logic [RA_W-1:0]     clr_row_r;
  logic [RA_W-1:0]     gen_row_r;
  logic [RA_W-1:0]     dn_row;
  logic [MAX_COLS-1:0] up_r, mid_r;

  logic                out_valid_r, out_cell_r;
  logic [ACT_W-1:0]    out_act_r;

  logic                cur_re, cur_we, nxt_re, nxt_we;
  logic [RA_W-1:0]     cur_raddr;
  logic [MAX_COLS-1:0] cur_wdata, gen_word;
  logic [MAX_COLS-1:0] cur_rdata, nxt_rdata;
  logic [MAX_COLS-1:0] bank_rdata [2];

  logic [MAX_COLS-1:0] up_lv, up_rv, md_lv, md_rv, dn_lv, dn_rv;
  logic [NBR_W-1:0]    nbr;

  // configuration registers, then saturate them to the supported sizes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_SIZE_RESET;
      grid_cols_r <= GRID_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_ROWS: grid_rows_r <= cfg_wdata;
        REG_GRID_COLS: grid_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_rows_r < CFG_W'(MIN_SIZE)) begin
      rows_eff = RC_W'(MIN_SIZE);
    end else if (32'(grid_rows_r) > 32'(MAX_ROWS)) begin
      rows_eff = RC_W'(MAX_ROWS);
    end else begin
      rows_eff = RC_W'(grid_rows_r);
    end
    if (grid_cols_r < CFG_W'(MIN_SIZE)) begin
      cols_eff = CC_W'(MIN_SIZE);
    end else if (32'(grid_cols_r) > 32'(MAX_COLS)) begin
      cols_eff = CC_W'(MAX_COLS);
    end else begin
      cols_eff = CC_W'(grid_cols_r);
    end
    last_row = RA_W'(rows_eff - RC_W'(1));
    last_col = CA_W'(cols_eff - CC_W'(1));
  end

  // capture the item; out-of-area coordinates fold to zero
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_act_r   <= in_action;
      item_alive_r <= in_alive;
      item_row_r   <= (32'(in_row) < 32'(rows_eff)) ? RA_W'(in_row) : '0;
      item_col_r   <= (32'(in_col) < 32'(cols_eff)) ? CA_W'(in_col) : '0;
    end
  end

  // bank select, clearing sweep and generation row counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= 1'b0;
      clr_row_r <= '0;
      gen_row_r <= '0;
    end else begin
      if (cmd.gen_swap) sel_r <= ~sel_r;
      if (cmd.clr) clr_row_r <= clr_row_r + RA_W'(1);
      if (cmd.gen_pre0) begin
        gen_row_r <= '0;
      end else if (cmd.gen_wr && !sts.row_last) begin
        gen_row_r <= gen_row_r + RA_W'(1);
      end
    end
  end

  assign dn_row = (gen_row_r == last_row) ? '0 : gen_row_r + RA_W'(1);

  // row window: up and middle rows held, lower row straight from the bank
  always_ff @(posedge clk) begin
    if (cmd.gen_pre1) up_r <= cur_rdata;
    if (cmd.gen_pre2) mid_r <= cur_rdata;
    if (cmd.gen_wr) begin
      up_r  <= mid_r;
      mid_r <= cur_rdata;
    end
  end

  always_comb begin
    cur_re = cmd.cell_rd | cmd.gen_pre0 | cmd.gen_pre1 | cmd.gen_rd;
    if (cmd.gen_pre0) begin
      cur_raddr = last_row;
    end else if (cmd.gen_pre1) begin
      cur_raddr = '0;
    end else if (cmd.gen_rd) begin
      cur_raddr = dn_row;
    end else begin
      cur_raddr = item_row_r;
    end
    nxt_re = cmd.gen_rd;
    cur_we = cmd.cell_fin && (item_act_r == ACT_WRITE);
    nxt_we = cmd.gen_wr;
    cur_wdata = cur_rdata;
    cur_wdata[item_col_r] = item_alive_r;
  end

  // one row of the next generation; inactive columns keep the old content
  always_comb begin
    up_lv = from_left(up_r, last_col);
    up_rv = from_right(up_r, last_col);
    md_lv = from_left(mid_r, last_col);
    md_rv = from_right(mid_r, last_col);
    dn_lv = from_left(cur_rdata, last_col);
    dn_rv = from_right(cur_rdata, last_col);
    nbr   = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      nbr = NBR_W'(up_lv[c]) + NBR_W'(up_r[c]) + NBR_W'(up_rv[c])
          + NBR_W'(md_lv[c]) + NBR_W'(md_rv[c])
          + NBR_W'(dn_lv[c]) + NBR_W'(cur_rdata[c]) + NBR_W'(dn_rv[c]);
      if (CA_W'(c) <= last_col) begin
        gen_word[c] = (nbr == NBR_BIRTH) || ((nbr == NBR_KEEP) && mid_r[c]);
      end else begin
        gen_word[c] = nxt_rdata[c];
      end
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic                is_cur;
    logic                we, re;
    logic [RA_W-1:0]     waddr, raddr;
    logic [MAX_COLS-1:0] wdata;

    always_comb begin
      is_cur = (sel_r == 1'(b));
      we     = cmd.clr | (is_cur ? cur_we : nxt_we);
      waddr  = cmd.clr ? clr_row_r : (is_cur ? item_row_r : gen_row_r);
      wdata  = cmd.clr ? '0 : (is_cur ? cur_wdata : gen_word);
      re     = is_cur ? cur_re : nxt_re;
      raddr  = is_cur ? cur_raddr : gen_row_r;
    end

    lats_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (bank_rdata[b])
    );
  end

  assign cur_rdata = bank_rdata[sel_r];
  assign nxt_rdata = bank_rdata[~sel_r];

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.cell_fin || cmd.gen_swap) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_fin) begin
      out_cell_r <= (item_act_r == ACT_WRITE) ? item_alive_r : cur_rdata[item_col_r];
      out_act_r  <= item_act_r;
    end else if (cmd.gen_swap) begin
      out_cell_r <= 1'b0;
      out_act_r  <= ACT_ADVANCE;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_alive  = out_cell_r;
  assign out_done_action = out_act_r;

  always_comb begin
    sts.clr_last = (clr_row_r == RA_W'(MAX_ROWS - 1));
    sts.row_last = (gen_row_r == last_row);
    sts.out_free = !out_valid_r || out_ready;
  end

endmodule

@@ rtl/life_automaton_torus_step.sv @@
// Cell write or read: the item passes CELL_RD, then CELL_FIN, which waits for a free result register.
// Generation: GEN_PRE0 to GEN_PRE2 load the row window, then GEN_RD and GEN_WR per row, then GEN_DONE.
// Result register frees the input side: a new item is taken while a result waits.
// Reset (synchronous, rst_n low) is followed by a sweep that clears both banks one row a cycle,
// with no item taken; configuration writes are taken throughout the sweep.
module life_automaton_torus_step import lats_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lats_in_if.sink               in_ch,
  lats_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // Each bank holds one grid row per word, MAX_COLS cells wide. The controller
  // steps the sequence: clearing sweep, read-modify-write of one cell, or the
  // generation walk. The datapath keeps the two banks, the row window used for
  // the neighbour count, the size registers and the result register.

  lats_cmd_t cmd;
  lats_sts_t sts;
  logic      in_ready;

  lats_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Generation walk per row: read the row below from the current bank and the
  // same row from the other bank, then write the new row into the other bank,
  // keeping its old bits beyond the active columns. Rows beyond the active area
  // are never written. The bank roles swap when the result register takes the result.
  lats_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_action       (in_ch.action),
    .in_row          (in_ch.row),
    .in_col          (in_ch.col),
    .in_alive        (in_ch.alive),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_cell_alive  (out_ch.cell_alive),
    .out_done_action (out_ch.done_action)
  );

  // Take an item only while idle; an unused action code is dropped silently.
  assign in_ch.ready = in_ready;

endmodule

@@ rtl/lats_chk.sv @@
`include "life_automaton_torus_step_defines.svh"

module lats_chk import lats_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_cell_alive,
  input logic [ACT_W-1:0] out_done_action
);

  logic adv_out;

  assign adv_out = out_valid && (out_done_action == ACT_ADVANCE);

  `LATS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `LATS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
  `LATS_ASSERT_SAME(a_adv_dead, adv_out, !out_cell_alive, "generation result carries a live cell")
  `LATS_ASSERT_SAME(a_free_after, $rose(out_valid), in_ready, "new result while still busy")

endmodule

bind life_automaton_torus_step lats_chk u_lats_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_cell_alive  (out_ch.cell_alive),
  .out_done_action (out_ch.done_action)
);

@@ sim/testbench.sv @@
module testbench;
  import lats_pkg::*;

  localparam int GRID_CELLS = DEF_MAX_ROWS * DEF_MAX_COLS;
  // Settling time covers a generation at full height, with a margin on top.
  localparam int SETTLE_CYCLES = 2 * DEF_MAX_ROWS + 24;

  typedef struct packed {
    logic [ACT_W-1:0]       action;
    logic [ROW_FIELD_W-1:0] row;
    logic [COL_FIELD_W-1:0] col;
    logic                   alive;
  } cell_item_t;

  typedef struct packed {
    logic             cell_alive;
    logic [ACT_W-1:0] done_action;
  } cell_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;

  lats_in_if  in_bus ();
  lats_out_if out_bus ();

  life_automaton_torus_step DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Items waiting to be offered, and results the grid copy says must come back.
  cell_item_t   pending_items[$];
  cell_result_t awaited_results[$];
  int unsigned  items_queued;
  int unsigned  items_taken;
  int unsigned  mismatches;
  bit           no_idling;

  // Own copy of the two cell banks, the bank select and the size registers.
  bit               cell_bank [2][GRID_CELLS];
  bit               bank_sel;
  logic [CFG_W-1:0] grid_rows_q;
  logic [CFG_W-1:0] grid_cols_q;

  // Saturate a size register to the range the grid can hold.
  function automatic int unsigned active_extent(logic [CFG_W-1:0] v, int unsigned limit);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic int live_at(bit b, int unsigned r, int unsigned c);
    return int'(cell_bank[b][r * DEF_MAX_COLS + c]);
  endfunction

  // Build the next generation in the other bank, then swap. Cells outside the
  // active area of the other bank keep whatever they held.
  function automatic void advance_generation(int unsigned nr, int unsigned nc);
    bit          src;
    bit          dst;
    int unsigned up, dn, lf, rt;
    int          cnt;
    src = bank_sel;
    dst = ~bank_sel;
    for (int unsigned r = 0; r < nr; r++) begin
      up = (r == 0) ? nr - 1 : r - 1;
      dn = (r + 1 >= nr) ? 0 : r + 1;
      for (int unsigned c = 0; c < nc; c++) begin
        lf = (c == 0) ? nc - 1 : c - 1;
        rt = (c + 1 >= nc) ? 0 : c + 1;
        cnt = live_at(src, up, lf) + live_at(src, up, c) + live_at(src, up, rt)
            + live_at(src, r, lf) + live_at(src, r, rt)
            + live_at(src, dn, lf) + live_at(src, dn, c) + live_at(src, dn, rt);
        if (cnt == NBR_BIRTH)
          cell_bank[dst][r * DEF_MAX_COLS + c] = 1'b1;
        else if (cnt == NBR_KEEP)
          cell_bank[dst][r * DEF_MAX_COLS + c] = cell_bank[src][r * DEF_MAX_COLS + c];
        else
          cell_bank[dst][r * DEF_MAX_COLS + c] = 1'b0;
      end
    end
    bank_sel = dst;
  endfunction

  // Apply one taken item to the grid copy and queue the result it must give.
  function automatic void predict_cell_result(cell_item_t it);
    int unsigned  nr, nc, r, c;
    cell_result_t res;
    nr = active_extent(grid_rows_q, DEF_MAX_ROWS);
    nc = active_extent(grid_cols_q, DEF_MAX_COLS);
    r  = it.row;
    c  = it.col;
    // Coordinates beyond the active area fold to index 0 in that dimension.
    if (r >= nr) r = 0;
    if (c >= nc) c = 0;
    res.cell_alive  = 1'b0;
    res.done_action = it.action;
    case (it.action)
      ACT_WRITE: begin
        cell_bank[bank_sel][r * DEF_MAX_COLS + c] = it.alive;
        res.cell_alive = it.alive;
        awaited_results.push_back(res);
      end
      ACT_READ: begin
        res.cell_alive = cell_bank[bank_sel][r * DEF_MAX_COLS + c];
        awaited_results.push_back(res);
      end
      ACT_ADVANCE: begin
        advance_generation(nr, nc);
        awaited_results.push_back(res);
      end
      default: ; // unused code: dropped, nothing comes back
    endcase
  endfunction

  function automatic void queue_item(logic [ACT_W-1:0] act, int unsigned r, int unsigned c,
                                     bit alive);
    cell_item_t it;
    it.action = act;
    it.row    = ROW_FIELD_W'(r);
    it.col    = COL_FIELD_W'(c);
    it.alive  = alive;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  // Driver: offer pending items, predict each one at the edge it is taken.
  cell_item_t offered;
  int         gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid  <= 1'b0;
      in_bus.action <= ACT_WRITE;
      in_bus.row    <= '0;
      in_bus.col    <= '0;
      in_bus.alive  <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_cell_result(offered);
        items_taken++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          // idle burst on the sending side
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          offered = pending_items.pop_front();
          in_bus.action <= offered.action;
          in_bus.row    <= offered.row;
          in_bus.col    <= offered.col;
          in_bus.alive  <= offered.alive;
          in_bus.valid  <= 1'b1;
          if (!no_idling && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 9);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every taken result against the oldest prediction, stall at random.
  cell_result_t seen;
  int           stall_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing awaited, cell_alive %0d done_action %0d",
                   $time, out_bus.cell_alive, out_bus.done_action);
          mismatches++;
        end else begin
          seen = awaited_results.pop_front();
          if (out_bus.cell_alive !== seen.cell_alive) begin
            $display("%0t: cell_alive mismatch, expected %0d, actual %0d",
                     $time, seen.cell_alive, out_bus.cell_alive);
            mismatches++;
          end
          if (out_bus.done_action !== seen.done_action) begin
            $display("%0t: done_action mismatch, expected %0d, actual %0d",
                     $time, seen.done_action, out_bus.done_action);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 6) == 0) begin
        // start a stall of random length
        stall_left = $urandom_range(0, 8);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Hold until every queued item is taken and every result is back.
  task automatic wait_results_home();
    do @(negedge clk);
    while (items_taken != items_queued || awaited_results.size() != 0);
  endtask

  // Drain, let a dropped item finish, then rewrite both size registers.
  task automatic set_grid_size(logic [CFG_W-1:0] rows_v, logic [CFG_W-1:0] cols_v);
    wait_results_home();
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_GRID_ROWS;
    cfg_wdata <= rows_v;
    @(posedge clk);
    grid_rows_q = rows_v;
    cfg_addr  <= REG_GRID_COLS;
    cfg_wdata <= cols_v;
    @(posedge clk);
    grid_cols_q = cols_v;
    cfg_we <= 1'b0;
  endtask

  // Out of range now and then, otherwise 3..12 or anywhere in 3..64.
  function automatic logic [CFG_W-1:0] pick_size();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return CFG_W'($urandom_range(0, 2));
    if (k == 1) return CFG_W'($urandom_range(65, 127));
    if (k < 6) return CFG_W'($urandom_range(3, 12));
    return CFG_W'($urandom_range(3, 64));
  endfunction

  // Random part: clusters of writes that can breed, a generation or two, reads
  // around the cluster; the rest is noise with any code and any coordinate.
  task automatic random_phase(int unsigned n_items, bit pause_midway);
    int unsigned nr, nc, made, br, bc, n_wr, n_adv, n_rd, act;
    nr   = active_extent(grid_rows_q, DEF_MAX_ROWS);
    nc   = active_extent(grid_cols_q, DEF_MAX_COLS);
    made = 0;
    while (made < n_items) begin
      if (pause_midway && made >= n_items / 2) begin
        // hold the sender until the block has nothing left to return
        wait_results_home();
        pause_midway = 1'b0;
      end
      if ($urandom_range(0, 9) < 7) begin
        br    = $urandom_range(0, nr - 1);
        bc    = $urandom_range(0, nc - 1);
        n_wr  = $urandom_range(3, 6);
        n_adv = $urandom_range(1, 2);
        n_rd  = $urandom_range(2, 4);
        repeat (n_wr)
          queue_item(ACT_WRITE, (br + $urandom_range(0, 2)) % nr,
                     (bc + $urandom_range(0, 2)) % nc, $urandom_range(0, 4) != 0);
        repeat (n_adv)
          queue_item(ACT_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1));
        repeat (n_rd)
          queue_item(ACT_READ, (br + $urandom_range(0, 3)) % nr,
                     (bc + $urandom_range(0, 3)) % nc, $urandom_range(0, 1));
        made += n_wr + n_adv + n_rd;
      end else begin
        act = $urandom_range(0, 3);
        queue_item(ACT_W'(act), $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 1));
        if (ACT_W'(act) != ACT_NONE) made++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = REG_GRID_ROWS;
    cfg_wdata     = '0;
    in_bus.valid  = 1'b0;
    in_bus.action = ACT_WRITE;
    in_bus.row    = '0;
    in_bus.col    = '0;
    in_bus.alive  = 1'b0;
    out_bus.ready = 1'b0;
    items_queued  = 0;
    items_taken   = 0;
    mismatches    = 0;
    no_idling     = 1'b0;
    bank_sel      = 1'b0;
    grid_rows_q   = GRID_SIZE_RESET;
    grid_cols_q   = GRID_SIZE_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Full 64 by 64 grid after reset: cleared corners, then a blinker lying
    // across the left/right seam that must turn upright across the top/bottom seam.
    queue_item(ACT_READ, 0, 0, 1'b0);
    queue_item(ACT_READ, 63, 63, 1'b1);
    queue_item(ACT_WRITE, 63, 63, 1'b1);
    queue_item(ACT_WRITE, 63, 63, 1'b0);
    queue_item(ACT_WRITE, 0, 63, 1'b1);
    queue_item(ACT_WRITE, 0, 0, 1'b1);
    queue_item(ACT_WRITE, 0, 1, 1'b1);
    queue_item(ACT_NONE, 63, 63, 1'b1);
    queue_item(ACT_ADVANCE, 0, 0, 1'b0);
    queue_item(ACT_READ, 63, 0, 1'b0);
    queue_item(ACT_READ, 1, 0, 1'b0);
    queue_item(ACT_READ, 0, 63, 1'b0);
    queue_item(ACT_READ, 0, 0, 1'b0);

    // Sizes below the minimum saturate to 3 by 3; on that torus every cell
    // touches all others, so three live cells fill it and a full grid dies.
    set_grid_size(CFG_W'(0), CFG_W'(2));
    queue_item(ACT_WRITE, 63, 63, 1'b1);
    queue_item(ACT_READ, 0, 0, 1'b0);
    queue_item(ACT_WRITE, 1, 1, 1'b1);
    queue_item(ACT_WRITE, 2, 2, 1'b1);
    queue_item(ACT_READ, 5, 2, 1'b0);
    queue_item(ACT_ADVANCE, 63, 63, 1'b1);
    queue_item(ACT_READ, 2, 0, 1'b0);
    queue_item(ACT_ADVANCE, 0, 0, 1'b0);
    queue_item(ACT_READ, 1, 2, 1'b0);
    queue_item(ACT_WRITE, 2, 1, 1'b0);

    // Sizes above the maximum saturate to 64.
    set_grid_size(CFG_W'(127), CFG_W'(127));
    random_phase(15, 1'b0);
    set_grid_size(CFG_W'(64), CFG_W'(3));
    random_phase(15, 1'b1);
    set_grid_size(CFG_W'(3), CFG_W'(64));
    random_phase(15, 1'b0);
    set_grid_size(pick_size(), pick_size());
    random_phase(15, 1'b0);
    set_grid_size(pick_size(), pick_size());
    random_phase(15, 1'b0);
    // last stretch runs flat out on both sides
    set_grid_size(pick_size(), pick_size());
    no_idling = 1'b1;
    random_phase(15, 1'b0);

    wait_results_home();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ life_automaton_torus_step.f @@
+incdir+rtl
rtl/lats_pkg.sv
rtl/lats_if.sv
rtl/lats_ram.sv
rtl/lats_ctrl.sv
rtl/lats_dp.sv
rtl/life_automaton_torus_step.sv
rtl/lats_chk.sv
sim/testbench.sv
